>>> rtl/gdc_pkg.sv
// Shared types, constants and tables for the Gaussian density block.
// Used by gdc_ctrl, gdc_dp and gaussian_density_cholesky; depends on nothing.
`default_nettype none

package gdc_pkg;

  localparam int MAX_DIM = 4;
  localparam int IDX_W   = 2;
  localparam int VAL_W   = 32;
  localparam int DIM_W   = 3;
  localparam int DENS_W  = 32;
  localparam int DIST_W  = 48;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int ACC_W   = 52;   // dot product sum and raw numerator
  localparam int NUM_W   = 48;   // numerator after clamping to +-2^46
  localparam int LS_W    = 40;   // log2 sums and the exponent, Q.24
  localparam int MUL_W   = 33;   // operand width of the shared multiplier
  localparam int PROD_W  = 2 * MUL_W;
  localparam int FRAC_W  = 24;
  localparam int QC_W    = 27;
  localparam int IT_W    = 5;

  localparam logic [DIM_W-1:0] DIM_RESET = 3'd2;

  localparam logic [24:0] LOG2E_Q24         = 25'd24204406;
  localparam logic [24:0] HALF_LOG2_2PI_Q24 = 25'd22242362;

  localparam logic [1:0] ACT_MEAN   = 2'd0;
  localparam logic [1:0] ACT_FACTOR = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_PREP     = 5'd1;
  localparam logic [4:0] OP_DOT_RD   = 5'd2;
  localparam logic [4:0] OP_DOT_MUL  = 5'd3;
  localparam logic [4:0] OP_DOT_ACC  = 5'd4;
  localparam logic [4:0] OP_DIAG_RD  = 5'd5;
  localparam logic [4:0] OP_DIAG_CHK = 5'd6;
  localparam logic [4:0] OP_DIV_SET  = 5'd7;
  localparam logic [4:0] OP_DIV      = 5'd8;
  localparam logic [4:0] OP_ZWR      = 5'd9;
  localparam logic [4:0] OP_SQ_MUL   = 5'd10;
  localparam logic [4:0] OP_SQ_ACC   = 5'd11;
  localparam logic [4:0] OP_LG_RD    = 5'd12;
  localparam logic [4:0] OP_LG_CHK   = 5'd13;
  localparam logic [4:0] OP_LG_NORM  = 5'd14;
  localparam logic [4:0] OP_LG_MUL   = 5'd15;
  localparam logic [4:0] OP_LG_UPD   = 5'd16;
  localparam logic [4:0] OP_LG_ADD   = 5'd17;
  localparam logic [4:0] OP_E_MUL    = 5'd18;
  localparam logic [4:0] OP_E_CALC   = 5'd19;
  localparam logic [4:0] OP_PW_MUL   = 5'd20;
  localparam logic [4:0] OP_PW_UPD   = 5'd21;
  localparam logic [4:0] OP_OUT      = 5'd22;

  typedef struct packed {
    logic            accept;
    logic [4:0]      op;
    logic [IDX_W-1:0] k;
    logic [IT_W-1:0] bitsel;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] i;
    logic [DIM_W-1:0] d;
    logic             prep_zero;
    logic             diag_bad;
    logic             div_ovf;
    logic             norm_done;
    logic             last_coord;
    logic             any_bad;
  } sts_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int s = 0; s < 32; s++) begin
      if (b > rem) b = b >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (b != 64'd0) begin
        if (rem >= res + b) begin
          rem = rem - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // n-th repeated square root of 2, in Q.30.
  function automatic logic [31:0] pow2_root(input int n);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int s = 0; s < 24; s++) begin
      if (s < n) r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

  // Entry k is the factor applied for fraction bit k of the exponent.
  localparam logic [31:0] ROOT_TAB [FRAC_W] = '{
    pow2_root(24), pow2_root(23), pow2_root(22), pow2_root(21),
    pow2_root(20), pow2_root(19), pow2_root(18), pow2_root(17),
    pow2_root(16), pow2_root(15), pow2_root(14), pow2_root(13),
    pow2_root(12), pow2_root(11), pow2_root(10), pow2_root(9),
    pow2_root(8),  pow2_root(7),  pow2_root(6),  pow2_root(5),
    pow2_root(4),  pow2_root(3),  pow2_root(2),  pow2_root(1)
  };

endpackage

`default_nettype wire

>>> rtl/gaussian_density_cholesky.sv
// Top level of the Gaussian density block: joins gdc_ctrl and gdc_dp.
// Depends on gdc_pkg, gdc_ctrl and gdc_dp.
`default_nettype none

// Evaluates a multivariate normal density one coordinate per transaction.
// Mean and factor loads are taken in the idle state. A sample coordinate i
// runs one multiply and accumulate step per earlier coordinate, then a
// restoring divider that is skipped when the diagonal is bad or the quotient
// saturates. The last coordinate of a point adds, for each of the d
// diagonals, one normalizing shift per leading zero below bit 30 and 24
// squarings on the shared 33x33 multiplier, and then the exp2 product
// before the result is registered; a bad diagonal skips its squarings and the
// exp2 product. The result register holds one transaction, so a new coordinate is taken while it waits.
module gaussian_density_cholesky (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gdc_pkg::DIM_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic [gdc_pkg::IDX_W-1:0]      in_row_index,
  input  logic [gdc_pkg::IDX_W-1:0]      in_col_index,
  input  logic signed [gdc_pkg::VAL_W-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gdc_pkg::DENS_W-1:0]     out_density,
  output logic [gdc_pkg::DIST_W-1:0]     out_distance_sq,
  output logic                           out_bad_factor
);
  import gdc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_action       (in_action),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_density     (out_density),
    .out_distance_sq (out_distance_sq),
    .out_bad_factor  (out_bad_factor)
  );

endmodule

`default_nettype wire

>>> rtl/gdc_dp.sv
// Datapath of the Gaussian density block: tables, shared multiplier, divider,
// log2/exp2 iterations and the result register. Depends on gdc_pkg.
`default_nettype none

module gdc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gdc_pkg::DIM_W-1:0]     cfg_data,
  input  logic [1:0]                    in_action,
  input  logic [gdc_pkg::IDX_W-1:0]     in_row_index,
  input  logic [gdc_pkg::IDX_W-1:0]     in_col_index,
  input  logic signed [gdc_pkg::VAL_W-1:0] in_value,
  input  gdc_pkg::cmd_t                 cmd,
  output gdc_pkg::sts_t                 sts,
  output logic [gdc_pkg::DENS_W-1:0]    out_density,
  output logic [gdc_pkg::DIST_W-1:0]    out_distance_sq,
  output logic                          out_bad_factor
);
  import gdc_pkg::*;

  logic [DIM_W-1:0]        dim_r;
  logic [DIM_W-1:0]        d_use;
  logic signed [VAL_W-1:0] mean_r [MAX_DIM];
  logic signed [VAL_W-1:0] fac_mem [MAX_DIM*MAX_DIM];
  logic signed [VAL_W-1:0] fac_rd_r;
  logic [ADDR_W-1:0]       rd_addr;

  logic signed [VAL_W-1:0] x_r;
  logic [DIM_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        i_r;
  logic [DIST_W-1:0]       qsum_r;
  logic signed [VAL_W-1:0] z_r [MAX_DIM];
  logic signed [VAL_W-1:0] zc_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [NUM_W-1:0] num_r;
  logic signed [VAL_W-1:0] diag_r;
  logic [31:0]             rem_r;
  logic [30:0]             dq_r;
  logic [31:0]             m_r;
  logic [4:0]              p_r;
  logic [FRAC_W-1:0]       frac_r;
  logic signed [LS_W-1:0]  logsum_r;
  logic                    bad_r;
  logic signed [15:0]      n_r;
  logic [FRAC_W-1:0]       f_r;
  logic [31:0]             pacc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [DENS_W-1:0]       dens_r;
  logic [DIST_W-1:0]       dist_r;
  logic                    badout_r;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  num_full;
  logic signed [ACC_W-1:0]  num_clamp;
  logic [46:0]              mag;
  logic                     diag_bad;
  logic                     div_ovf;
  logic [32:0]              div_t;
  logic                     div_ge;
  logic signed [VAL_W-1:0]  zval;
  logic [DIST_W:0]          sq_sum;
  logic [QC_W-1:0]          qc;
  logic [31:0]              lg_t;
  logic signed [5:0]        pm16;
  logic signed [LS_W-1:0]   e_val;
  logic [5:0]               rsh;
  logic [DENS_W-1:0]        dens_val;
  logic [DIM_W-1:0]         i_next;

  always_comb begin
    if (dim_r == '0) begin
      d_use = DIM_W'(1);
    end else if (dim_r > DIM_W'(MAX_DIM)) begin
      d_use = DIM_W'(MAX_DIM);
    end else begin
      d_use = dim_r;
    end
  end

  always_comb begin
    case (cmd.op)
      OP_DOT_RD:  rd_addr = {i_r, cmd.k};
      OP_DIAG_RD: rd_addr = {i_r, i_r};
      OP_LG_RD:   rd_addr = {cmd.k, cmd.k};
      default:    rd_addr = '0;
    endcase
  end

  // Factor table: one write port from the input, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.accept && in_action == ACT_FACTOR && in_col_index <= in_row_index) begin
      fac_mem[{in_row_index, in_col_index}] <= in_value;
    end
    fac_rd_r <= fac_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_action == ACT_MEAN) begin
      mean_r[in_row_index] <= in_value;
    end
  end

  assign qc = (qsum_r > DIST_W'(64'd1 << 26)) ? QC_W'(64'd1 << 26) : qsum_r[QC_W-1:0];

  always_comb begin
    case (cmd.op)
      OP_DOT_MUL: begin
        mul_a = MUL_W'(z_r[cmd.k]);
        mul_b = MUL_W'(fac_rd_r);
      end
      OP_SQ_MUL: begin
        mul_a = MUL_W'(zc_r);
        mul_b = MUL_W'(zc_r);
      end
      OP_LG_MUL: begin
        mul_a = $signed({1'b0, m_r});
        mul_b = $signed({1'b0, m_r});
      end
      OP_E_MUL: begin
        mul_a = $signed({{(MUL_W-QC_W){1'b0}}, qc});
        mul_b = $signed({8'd0, LOG2E_Q24});
      end
      OP_PW_MUL: begin
        mul_a = $signed({1'b0, pacc_r});
        mul_b = $signed({1'b0, ROOT_TAB[cmd.bitsel]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  assign num_full = ACC_W'(x_r) - ACC_W'(mean_r[i_r]) - acc_r;

  always_comb begin
    if (num_full > 52'sh400000000000) begin
      num_clamp = 52'sh400000000000;
    end else if (num_full < -52'sh400000000000) begin
      num_clamp = -52'sh400000000000;
    end else begin
      num_clamp = num_full;
    end
  end

  assign mag      = num_r[NUM_W-1] ? 47'(-num_r) : 47'(num_r);
  assign diag_bad = diag_r[VAL_W-1] || (diag_r == '0);
  // The quotient fits in 31 bits unless |num| >= diag * 2^15.
  assign div_ovf  = mag >= {1'b0, diag_r[30:0], 15'd0};

  assign div_t  = {rem_r, dq_r[30]};
  assign div_ge = div_t >= {2'b00, diag_r[30:0]};

  always_comb begin
    if (diag_bad) begin
      zval = '0;
    end else if (div_ovf) begin
      zval = num_r[NUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (num_r[NUM_W-1]) begin
      zval = $signed(32'd0 - {1'b0, dq_r});
    end else begin
      zval = $signed({1'b0, dq_r});
    end
  end

  assign sq_sum = {1'b0, qsum_r} + {1'b0, prod_r[63:16]};
  assign lg_t   = prod_r[61:30];
  assign pm16   = $signed({1'b0, p_r}) - 6'sd16;
  assign e_val  = -LS_W'(prod_r[50:17]) - LS_W'(d_use) * LS_W'(HALF_LOG2_2PI_Q24) - logsum_r;
  assign rsh    = 6'(16'sd6 - n_r);
  assign i_next = {1'b0, i_r} + 3'd1;

  always_comb begin
    if (bad_r) begin
      dens_val = '0;
    end else if (n_r >= 16'sd8) begin
      dens_val = '1;
    end else if (n_r < -16'sd40) begin
      dens_val = '0;
    end else if (n_r == 16'sd7) begin
      dens_val = {pacc_r[30:0], 1'b0};
    end else if (n_r == 16'sd6) begin
      dens_val = pacc_r;
    end else begin
      dens_val = pacc_r >> rsh;
    end
  end

  // State that reset defines.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= DIM_RESET;
      cnt_r  <= '0;
      qsum_r <= '0;
      for (int j = 0; j < MAX_DIM; j++) z_r[j] <= '0;
    end else begin
      if (cfg_we) dim_r <= cfg_data;
      case (cmd.op)
        OP_PREP: begin
          if (cnt_r >= d_use) qsum_r <= '0;
        end
        OP_ZWR: z_r[i_r] <= zval;
        OP_SQ_ACC: begin
          qsum_r <= sq_sum[DIST_W] ? '1 : sq_sum[DIST_W-1:0];
          cnt_r  <= i_next;
        end
        OP_OUT: begin
          cnt_r  <= '0;
          qsum_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.accept && in_action == ACT_SAMPLE) x_r <= in_value;
    case (cmd.op)
      OP_PREP: begin
        i_r      <= (cnt_r >= d_use) ? '0 : cnt_r[IDX_W-1:0];
        acc_r    <= '0;
        logsum_r <= '0;
        bad_r    <= 1'b0;
      end
      OP_DOT_ACC: acc_r <= acc_r + ACC_W'($signed(prod_r[63:16]));
      OP_DIAG_CHK: begin
        diag_r <= fac_rd_r;
        num_r  <= NUM_W'(num_clamp);
      end
      OP_DIV_SET: begin
        rem_r <= mag[46:15];
        dq_r  <= {mag[14:0], 16'd0};
      end
      OP_DIV: begin
        rem_r <= div_ge ? 32'(div_t - {2'b00, diag_r[30:0]}) : div_t[31:0];
        dq_r  <= {dq_r[29:0], div_ge};
      end
      OP_ZWR: zc_r <= zval;
      OP_LG_CHK: begin
        diag_r <= fac_rd_r;
        m_r    <= fac_rd_r;
        p_r    <= 5'd30;
        frac_r <= '0;
      end
      OP_LG_NORM: begin
        if (diag_bad) begin
          bad_r <= 1'b1;
        end else if (!m_r[30]) begin
          m_r <= m_r << 1;
          p_r <= p_r - 5'd1;
        end
      end
      OP_LG_UPD: begin
        if (lg_t[31]) begin
          m_r    <= {1'b0, lg_t[31:1]};
          frac_r <= {frac_r[FRAC_W-2:0], 1'b1};
        end else begin
          m_r    <= lg_t;
          frac_r <= {frac_r[FRAC_W-2:0], 1'b0};
        end
      end
      OP_LG_ADD: begin
        logsum_r <= logsum_r + LS_W'($signed({pm16, 24'd0}))
                    + LS_W'($signed({1'b0, frac_r}));
      end
      OP_E_CALC: begin
        n_r    <= e_val[LS_W-1:24];
        f_r    <= e_val[23:0];
        pacc_r <= 32'h4000_0000;
      end
      OP_PW_UPD: begin
        if (f_r[FRAC_W-1]) pacc_r <= prod_r[61:30];
        f_r <= f_r << 1;
      end
      OP_OUT: begin
        dens_r   <= dens_val;
        dist_r   <= qsum_r;
        badout_r <= bad_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.i          = i_r;
    sts.d          = d_use;
    sts.prep_zero  = (cnt_r >= d_use) || (cnt_r == '0);
    sts.diag_bad   = diag_bad;
    sts.div_ovf    = div_ovf;
    sts.norm_done  = m_r[30];
    sts.last_coord = i_next >= d_use;
    sts.any_bad    = bad_r;
  end

  assign out_density     = dens_r;
  assign out_distance_sq = dist_r;
  assign out_bad_factor  = badout_r;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DIM_W'(MAX_DIM))
    else $error("coordinate counter beyond the largest dimension");

  a_out_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |=> (cnt_r == '0 && qsum_r == '0))
    else $error("point state not cleared after a result");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_DIV |-> rem_r < $unsigned(diag_r))
    else $error("divider remainder not below the divisor");

  a_lg_norm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LG_MUL |-> (m_r[30] && !m_r[31]))
    else $error("log2 mantissa not normalized before squaring");
`endif

endmodule

`default_nettype wire

>>> rtl/gdc_ctrl.sv
// Sequencer of the Gaussian density block: input handshake, step commands to
// gdc_dp and the result valid flag. Depends on gdc_pkg.
`default_nettype none

module gdc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_action,
  output logic          out_valid,
  input  logic          out_ready,
  input  gdc_pkg::sts_t sts,
  output gdc_pkg::cmd_t cmd
);
  import gdc_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_PREP     = 5'd1;
  localparam logic [4:0] S_DOT_RD   = 5'd2;
  localparam logic [4:0] S_DOT_MUL  = 5'd3;
  localparam logic [4:0] S_DOT_ACC  = 5'd4;
  localparam logic [4:0] S_DIAG_RD  = 5'd5;
  localparam logic [4:0] S_DIAG_CHK = 5'd6;
  localparam logic [4:0] S_DIV_SET  = 5'd7;
  localparam logic [4:0] S_DIV      = 5'd8;
  localparam logic [4:0] S_ZWR      = 5'd9;
  localparam logic [4:0] S_SQ_MUL   = 5'd10;
  localparam logic [4:0] S_SQ_ACC   = 5'd11;
  localparam logic [4:0] S_LG_RD    = 5'd12;
  localparam logic [4:0] S_LG_CHK   = 5'd13;
  localparam logic [4:0] S_LG_NORM  = 5'd14;
  localparam logic [4:0] S_LG_MUL   = 5'd15;
  localparam logic [4:0] S_LG_UPD   = 5'd16;
  localparam logic [4:0] S_LG_ADD   = 5'd17;
  localparam logic [4:0] S_E_MUL    = 5'd18;
  localparam logic [4:0] S_E_CALC   = 5'd19;
  localparam logic [4:0] S_PW_MUL   = 5'd20;
  localparam logic [4:0] S_PW_UPD   = 5'd21;
  localparam logic [4:0] S_FIN      = 5'd22;

  logic [4:0]       state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IT_W-1:0]  it_r, it_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    it_nxt     = it_r;
    cmd.accept = accept;
    cmd.op     = OP_NONE;
    cmd.k      = k_r;
    cmd.bitsel = it_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (accept && in_action == ACT_SAMPLE) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.op = OP_PREP;
        k_nxt  = '0;
        state_nxt = sts.prep_zero ? S_DIAG_RD : S_DOT_RD;
      end
      S_DOT_RD: begin
        cmd.op = OP_DOT_RD;
        state_nxt = S_DOT_MUL;
      end
      S_DOT_MUL: begin
        cmd.op = OP_DOT_MUL;
        state_nxt = S_DOT_ACC;
      end
      S_DOT_ACC: begin
        cmd.op = OP_DOT_ACC;
        if (k_r == IDX_W'(sts.i - 2'd1)) begin
          state_nxt = S_DIAG_RD;
        end else begin
          k_nxt = k_r + 2'd1;
          state_nxt = S_DOT_RD;
        end
      end
      S_DIAG_RD: begin
        cmd.op = OP_DIAG_RD;
        state_nxt = S_DIAG_CHK;
      end
      S_DIAG_CHK: begin
        cmd.op = OP_DIAG_CHK;
        state_nxt = S_DIV_SET;
      end
      S_DIV_SET: begin
        cmd.op = OP_DIV_SET;
        it_nxt = 5'd30;
        state_nxt = (sts.diag_bad || sts.div_ovf) ? S_ZWR : S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        it_nxt = it_r - 5'd1;
        if (it_r == '0) state_nxt = S_ZWR;
      end
      S_ZWR: begin
        cmd.op = OP_ZWR;
        state_nxt = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd.op = OP_SQ_MUL;
        state_nxt = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.op = OP_SQ_ACC;
        k_nxt  = '0;
        state_nxt = sts.last_coord ? S_LG_RD : S_IDLE;
      end
      S_LG_RD: begin
        cmd.op = OP_LG_RD;
        state_nxt = S_LG_CHK;
      end
      S_LG_CHK: begin
        cmd.op = OP_LG_CHK;
        state_nxt = S_LG_NORM;
      end
      S_LG_NORM: begin
        cmd.op = OP_LG_NORM;
        it_nxt = 5'd23;
        // A bad diagonal only sets the flag; its log term is never used.
        if (sts.diag_bad) begin
          state_nxt = S_LG_ADD;
        end else if (sts.norm_done) begin
          state_nxt = S_LG_MUL;
        end
      end
      S_LG_MUL: begin
        cmd.op = OP_LG_MUL;
        state_nxt = S_LG_UPD;
      end
      S_LG_UPD: begin
        cmd.op = OP_LG_UPD;
        it_nxt = it_r - 5'd1;
        state_nxt = (it_r == '0) ? S_LG_ADD : S_LG_MUL;
      end
      S_LG_ADD: begin
        cmd.op = OP_LG_ADD;
        if ({1'b0, k_r} == sts.d - 3'd1) begin
          state_nxt = sts.any_bad ? S_FIN : S_E_MUL;
        end else begin
          k_nxt = k_r + 2'd1;
          state_nxt = S_LG_RD;
        end
      end
      S_E_MUL: begin
        cmd.op = OP_E_MUL;
        state_nxt = S_E_CALC;
      end
      S_E_CALC: begin
        cmd.op = OP_E_CALC;
        it_nxt = 5'd23;
        state_nxt = S_PW_MUL;
      end
      S_PW_MUL: begin
        cmd.op = OP_PW_MUL;
        state_nxt = S_PW_UPD;
      end
      S_PW_UPD: begin
        cmd.op = OP_PW_UPD;
        it_nxt = it_r - 5'd1;
        state_nxt = (it_r == '0) ? S_FIN : S_PW_MUL;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finishing step");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> state_r == S_FIN)
    else $error("new result would overwrite one not yet taken");

  a_it_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LG_MUL || state_r == S_PW_MUL) |-> it_r <= 5'd23)
    else $error("iteration count beyond the fraction width");
`endif

endmodule

`default_nettype wire
